### rtl/grma_pkg.sv
// Shared types and constants for the glitch-rejecting moving average.
// Used by the front, queue, back and top-level modules.
package grma_pkg;

    localparam int SAMPLE_W = 12;
    localparam int COUNT_W  = 5;
    localparam int SUM_W    = 16;

    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;

    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [1:0] REG_LOW_FLOOR   = 2'd0;
    localparam logic [1:0] REG_MAX_STEP    = 2'd1;
    localparam logic [1:0] REG_MAX_REJECTS = 2'd2;

    localparam logic [SAMPLE_W-1:0] LOW_FLOOR_RST   = 12'd200;
    localparam logic [SAMPLE_W-1:0] MAX_STEP_RST    = 12'd50;
    localparam logic [COUNT_W-1:0]  MAX_REJECTS_RST = 5'd20;

    typedef struct packed {
        logic [SAMPLE_W-1:0] low_floor;
        logic [SAMPLE_W-1:0] max_step;
        logic [COUNT_W-1:0]  max_rejects;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] kept;
        logic                rejected;
    } q_item_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

### rtl/grma_front.sv
// Front end: accepts samples, classifies them and decides the kept value.
// Depends on grma_pkg; pushes classified beats into grma_queue.
module grma_front
    import grma_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] sample,
    input  q_status_t           q_status,
    output logic                push,
    output q_item_t             push_item
);

    logic [SAMPLE_W-1:0] prev_reg;
    logic [SAMPLE_W-1:0] prev_next;
    logic [COUNT_W-1:0]  rej_cnt_reg;
    logic [COUNT_W-1:0]  rej_cnt_next;
    logic [SAMPLE_W-1:0] diff;
    logic                suspect;
    logic                reject;

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        diff    = (sample >= prev_reg) ? (sample - prev_reg) : (prev_reg - sample);
        suspect = (sample < cfg.low_floor) || (diff > cfg.max_step);
        reject  = (rej_cnt_reg < cfg.max_rejects) && suspect;

        push_item.rejected = reject;
        push_item.kept     = reject ? prev_reg : sample;

        prev_next    = prev_reg;
        rej_cnt_next = rej_cnt_reg;
        if (push)
        begin
            if (reject)
            begin
                rej_cnt_next = rej_cnt_reg + COUNT_W'(1);
            end
            else
            begin
                rej_cnt_next = '0;
                prev_next    = sample;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            rej_cnt_reg <= '0;
        end
        else
        begin
            prev_reg    <= prev_next;
            rej_cnt_reg <= rej_cnt_next;
        end
    end

endmodule

### rtl/grma_queue.sv
// Two-entry queue between the classifying front end and the averaging back end.
// Depends on grma_pkg for the entry and status types.
module grma_queue
    import grma_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_item_t   push_item,
    input  logic      pop,
    output q_item_t   pop_item,
    output q_status_t status
);

    q_item_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign pop_item     = entry_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/grma_back.sv
// Back end: window ring, running sum, divide by WINDOW and output register.
// Depends on grma_pkg; pops beats from grma_queue.
module grma_back
    import grma_pkg::*;
#(
    parameter int WINDOW = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  q_status_t           q_status,
    input  q_item_t             pop_item,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] average,
    output logic [SAMPLE_W-1:0] kept_value,
    output logic                was_rejected
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SHIFT  = SUM_W + $clog2(WINDOW);
    localparam int MULT_W = SHIFT + 1;
    localparam int PROD_W = SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] MULT = MULT_W'(((2 ** SHIFT) + WINDOW - 1) / WINDOW);

    logic [SAMPLE_W-1:0] ring_reg [WINDOW];
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;

    logic                a_valid_reg;
    logic                a_valid_next;
    logic [SUM_W-1:0]    a_sum_reg;
    logic [SAMPLE_W-1:0] a_kept_reg;
    logic                a_rej_reg;
    logic                a_adv;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SAMPLE_W-1:0] out_avg_reg;
    logic [SAMPLE_W-1:0] out_kept_reg;
    logic                out_rej_reg;
    logic [PROD_W-1:0]   product;

    assign a_adv = a_valid_reg && (!out_valid_reg || m_tready);
    assign pop   = !q_status.empty && (!a_valid_reg || a_adv);

    always_comb
    begin
        sum_next  = sum_reg - SUM_W'(ring_reg[slot_reg]) + SUM_W'(pop_item.kept);
        slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);

        a_valid_next = a_valid_reg;
        if (pop)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (a_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // exact reciprocal: M = ceil(2^SHIFT / WINDOW) covers every 16-bit sum
        product = PROD_W'(a_sum_reg) * PROD_W'(MULT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
            slot_reg      <= '0;
            sum_reg       <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                ring_reg[slot_reg] <= pop_item.kept;
                slot_reg           <= slot_next;
                sum_reg            <= sum_next;
            end
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_sum_reg  <= sum_next;
            a_kept_reg <= pop_item.kept;
            a_rej_reg  <= pop_item.rejected;
        end
        if (a_adv)
        begin
            out_avg_reg  <= product[SHIFT +: SAMPLE_W];
            out_kept_reg <= a_kept_reg;
            out_rej_reg  <= a_rej_reg;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign average      = out_avg_reg;
    assign kept_value   = out_kept_reg;
    assign was_rejected = out_rej_reg;

endmodule

### rtl/glitch_rejecting_moving_average_core.sv
// Glitch-rejecting moving average over one touch-panel ADC axis, one result beat
// per sample beat. While m_tready stays high the sustained rate is one beat per
// clock: the running-sum update in the back end retires one window slot per cycle.
// An accepted sample passes through the queue write, then the sum stage, then the
// divide and output register before its result shows on m_tdata. A two-entry queue
// lets the input keep flowing while a result waits. The window ring is cleared by
// reset, so the average ramps up from zero over the first WINDOW samples.
// Registers: low_floor at 0x0, max_step at 0x4, max_rejects at 0x8; write them only
// while the block is idle.
// Depends on grma_pkg, grma_front, grma_queue and grma_back.
module glitch_rejecting_moving_average_core
    import grma_pkg::*;
#(
    parameter int WINDOW = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [11:0] sample, [15:12] zero
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,   // [11:0] average, [23:12] kept_value
    output logic               m_tuser    // [0] was_rejected
);

    cfg_t                cfg_reg;
    cfg_t                cfg_next;
    logic                cfg_wr;
    logic [1:0]          reg_idx;

    logic                push;
    q_item_t             push_item;
    logic                pop;
    q_item_t             pop_item;
    q_status_t           q_status;
    logic [SAMPLE_W-1:0] average;
    logic [SAMPLE_W-1:0] kept_value;
    logic                was_rejected;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_LOW_FLOOR:   cfg_next.low_floor   = pwdata[SAMPLE_W-1:0];
                REG_MAX_STEP:    cfg_next.max_step    = pwdata[SAMPLE_W-1:0];
                REG_MAX_REJECTS: cfg_next.max_rejects = pwdata[COUNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end

        case (reg_idx)
            REG_LOW_FLOOR:   prdata = PDATA_W'(cfg_reg.low_floor);
            REG_MAX_STEP:    prdata = PDATA_W'(cfg_reg.max_step);
            REG_MAX_REJECTS: prdata = PDATA_W'(cfg_reg.max_rejects);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_floor   <= LOW_FLOOR_RST;
            cfg_reg.max_step    <= MAX_STEP_RST;
            cfg_reg.max_rejects <= MAX_REJECTS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    grma_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sample    (s_tdata[SAMPLE_W-1:0]),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    grma_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    grma_back #(
        .WINDOW (WINDOW)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop_item     (pop_item),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .average      (average),
        .kept_value   (kept_value),
        .was_rejected (was_rejected)
    );

    assign m_tdata = {kept_value, average};
    assign m_tuser = was_rejected;

    a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue popped while empty");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("queue pushed while full");

    a_queue_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_queue_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (q_status.count == $past(q_status.count) + QCNT_W'(1)))
        else $error("queue count did not follow a push");

endmodule

### sim/glitch_rejecting_moving_average_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for glitch_rejecting_moving_average_core: directed table plus
// random sample streams under several idle/stall mixes. Depends on grma_pkg and the RTL.
module glitch_rejecting_moving_average_core_test;
    import grma_pkg::*;

    localparam int WINDOW       = 10;
    localparam int SETTLE       = 8;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_BEATS  = 226;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 40;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic [SAMPLE_W-1:0] kept;
        logic                rejected;
    } smooth_t;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_CHECKED, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        smooth_t     want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 29;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_CHECKED, 2'd0, 32'd0,           '{12'd0,    12'd0,    1'b1}},
        '{ROW_CHECKED, 2'd0, 32'd4095,        '{12'd0,    12'd0,    1'b1}},
        '{ROW_WRITE,   REG_MAX_REJECTS, 32'd0, '0},
        '{ROW_CHECKED, 2'd0, 32'd4095,        '{12'd409,  12'd4095, 1'b0}},
        '{ROW_CHECKED, 2'd0, 32'd0,           '{12'd409,  12'd0,    1'b0}},
        '{ROW_WRITE,   REG_MAX_REJECTS, 32'hFFFF_FFE1, '0},
        '{ROW_WRITE,   REG_LOW_FLOOR,   32'hFFFF_F000, '0},
        '{ROW_WRITE,   REG_MAX_STEP,    32'h0000_1FFF, '0},
        '{ROW_CHECKED, 2'd0, 32'd4095,        '{12'd819,  12'd4095, 1'b0}},
        '{ROW_CHECKED, 2'd0, 32'd0,           '{12'd819,  12'd0,    1'b0}},
        '{ROW_WRITE,   REG_MAX_STEP,    32'd0,    '0},
        '{ROW_WRITE,   REG_LOW_FLOOR,   32'd4095, '0},
        '{ROW_WRITE,   REG_UNUSED,      32'hFFFF_FFFF, '0},
        '{ROW_CHECKED, 2'd0, 32'd4094,        '{12'd819,  12'd0,    1'b1}},
        '{ROW_CHECKED, 2'd0, 32'd4095,        '{12'd1228, 12'd4095, 1'b0}},
        '{ROW_CHECKED, 2'd0, 32'd4095,        '{12'd1638, 12'd4095, 1'b0}},
        '{ROW_CHECKED, 2'd0, 32'd4095,        '{12'd2047, 12'd4095, 1'b0}},
        '{ROW_CHECKED, 2'd0, 32'd4095,        '{12'd2457, 12'd4095, 1'b0}},
        '{ROW_WRITE,   REG_LOW_FLOOR,   32'd200, '0},
        '{ROW_WRITE,   REG_MAX_STEP,    32'd50,  '0},
        '{ROW_WRITE,   REG_MAX_REJECTS, 32'd31,  '0},
        '{ROW_SAMPLE,  2'd0, 32'd4046, '0},
        '{ROW_SAMPLE,  2'd0, 32'd4095, '0},
        '{ROW_SAMPLE,  2'd0, 32'd4044, '0},
        '{ROW_SAMPLE,  2'd0, 32'd199,  '0},
        '{ROW_SAMPLE,  2'd0, 32'd200,  '0},
        '{ROW_SAMPLE,  2'd0, 32'd2730, '0},
        '{ROW_SAMPLE,  2'd0, 32'd1365, '0},
        '{ROW_SAMPLE,  2'd0, 32'd4095, '0}
    };

    logic               clk;
    logic               rst_n    = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [15:0]        s_tdata  = '0;  // [11:0] sample, [15:12] zero
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [23:0]        m_tdata;        // [11:0] average, [23:12] kept_value
    logic               m_tuser;        // [0] was_rejected

    // filter mirror: configuration and state
    logic [SAMPLE_W-1:0] floor_cfg        = LOW_FLOOR_RST;
    logic [SAMPLE_W-1:0] step_cfg         = MAX_STEP_RST;
    logic [COUNT_W-1:0]  reject_limit_cfg = MAX_REJECTS_RST;
    logic [SAMPLE_W-1:0] last_kept        = '0;
    logic [COUNT_W-1:0]  reject_run       = '0;
    logic [SAMPLE_W-1:0] ring [WINDOW]    = '{default: '0};
    int                  ring_slot        = 0;
    logic [SUM_W-1:0]    ring_sum         = '0;

    smooth_t     expected_out [$];
    smooth_t     want_beat;
    int          errors    = 0;
    int unsigned cycles    = 0;
    int          gap_pct   = 0;
    int          stall_pct = 0;
    logic        hold_kick = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;

    glitch_rejecting_moving_average_core #(.WINDOW(WINDOW)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic smooth_t filter_sample(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] step_gap;
        logic                suspect;
        smooth_t             r;
        step_gap = (s >= last_kept) ? s - last_kept : last_kept - s;
        suspect  = (s < floor_cfg) || (step_gap > step_cfg);
        r.rejected = (reject_run < reject_limit_cfg) && suspect;
        if (r.rejected)
        begin
            reject_run = reject_run + 1'b1;
            r.kept     = last_kept;
        end
        else
        begin
            reject_run = '0;
            r.kept     = s;
            last_kept  = s;
        end
        ring_sum        = ring_sum - ring[ring_slot] + r.kept;
        ring[ring_slot] = r.kept;
        ring_slot       = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
        r.average       = SAMPLE_W'(ring_sum / WINDOW);
        return r;
    endfunction

    // mostly small steps around the kept value, plus glitches and step-edge jumps
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int          span;
        int          v;
        int unsigned r;
        r    = $urandom_range(99);
        span = (step_cfg > 12'd300) ? 300 : int'(step_cfg);
        if (r < 60)
            v = int'(last_kept) + int'($urandom_range(2 * span)) - span;
        else if (r < 68)
        begin
            v = int'(step_cfg) + int'($urandom_range(1));
            v = ($urandom_range(1) == 1) ? int'(last_kept) + v : int'(last_kept) - v;
        end
        else if (r < 78)
            v = (floor_cfg == '0) ? 0 : int'($urandom_range(int'(floor_cfg) - 1));
        else if (r < 85)
            v = ($urandom_range(1) == 1) ? 4095 : 0;
        else
            v = int'($urandom_range(4095));
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < REPORT_LIMIT)
            $display("cycle %0d: %s mismatch, got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_LOW_FLOOR:   floor_cfg        = value[SAMPLE_W-1:0];
            REG_MAX_STEP:    step_cfg         = value[SAMPLE_W-1:0];
            REG_MAX_REJECTS: reject_limit_cfg = value[COUNT_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_beat(input logic [SAMPLE_W-1:0] v);
        if ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, v};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // receiver: random stalls plus a single long hold-off in the last random phase
    always @(posedge clk)
    begin
        if (hold_kick != hold_seen)
        begin
            hold_seen = hold_kick;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_out.size() == 0)
                report_mismatch("unexpected beat", int'(m_tdata), 0);
            else
            begin
                want_beat = expected_out.pop_front();
                if (m_tdata[11:0] !== want_beat.average)
                    report_mismatch("average", int'(m_tdata[11:0]), int'(want_beat.average));
                if (m_tdata[23:12] !== want_beat.kept)
                    report_mismatch("kept_value", int'(m_tdata[23:12]), int'(want_beat.kept));
                if (m_tuser !== want_beat.rejected)
                    report_mismatch("was_rejected", int'(m_tuser), int'(want_beat.rejected));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t           row;
        smooth_t             predicted;
        logic [SAMPLE_W-1:0] v;
        logic [31:0]         junk;
        logic [SAMPLE_W-1:0] floor_val;
        logic [SAMPLE_W-1:0] step_val;
        logic [COUNT_W-1:0]  limit_val;
        int                  stall_val;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_WRITE)
            begin
                wait_idle();
                reg_write(row.reg_idx, row.value);
            end
            else
            begin
                send_beat(row.value[SAMPLE_W-1:0]);
                predicted = filter_sample(row.value[SAMPLE_W-1:0]);
                expected_out.push_back((row.kind == ROW_CHECKED) ? row.want : predicted);
            end
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    floor_val = 12'd200;  step_val = 12'd50;   limit_val = 5'd3;
                    gap_pct = 0;  stall_val = 0;
                end
                1:
                begin
                    floor_val = SAMPLE_W'($urandom_range(800));
                    step_val  = SAMPLE_W'($urandom_range(200));
                    limit_val = COUNT_W'($urandom_range(6));
                    gap_pct = 46; stall_val = 0;
                end
                2:
                begin
                    floor_val = 12'd0;    step_val = 12'd4095; limit_val = 5'd31;
                    gap_pct = 0;  stall_val = 46;
                end
                3:
                begin
                    floor_val = 12'd4095; step_val = 12'd0;    limit_val = 5'd2;
                    gap_pct = 18; stall_val = 18;
                end
                default:
                begin
                    floor_val = SAMPLE_W'($urandom_range(1500));
                    step_val  = SAMPLE_W'($urandom_range(4095));
                    limit_val = COUNT_W'($urandom_range(31));
                    gap_pct = 0;  stall_val = 0;
                end
            endcase
            junk = $urandom();
            reg_write(REG_LOW_FLOOR, {junk[31:12], floor_val});
            junk = $urandom();
            reg_write(REG_MAX_STEP, {junk[31:12], step_val});
            junk = $urandom();
            reg_write(REG_MAX_REJECTS, {junk[31:5], limit_val});
            stall_pct <= stall_val;
            if (ph == 4)
                hold_kick <= ~hold_kick;
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                v = pick_sample();
                send_beat(v);
                expected_out.push_back(filter_sample(v));
            end
        end

        wait_idle();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
